### design/svpwm_min_max_injection_modulator_defines.svh
// assertion macros for the svpwm modulator
// used by the top level only; no other dependencies
`ifndef SVPWM_MIN_MAX_INJECTION_MODULATOR_DEFINES_SVH
`define SVPWM_MIN_MAX_INJECTION_MODULATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SVPWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svpwm assertion failed");
`define SVPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svpwm assertion failed");
`else
`define SVPWM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SVPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/svpwm_pkg.sv
// shared widths, register codes, reset values and the sine table builder
// no dependencies
`default_nettype none

package svpwm_pkg;

    localparam int VOLT_BITS   = 16;
    localparam int ANGLE_BITS  = 16;
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_AW     = $clog2(SINE_DEPTH);
    localparam int CFG_BITS    = VOLT_BITS - 1;
    localparam int PERIOD_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_TDATA_BITS  = 48;
    localparam int OUT_TDATA_BITS = 128;

    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [VOLT_BITS-1:0] SQRT3_HALF_Q15 = 16'sd28378;

    localparam logic [CFG_BITS-1:0]    BUS_RESET    = 15'd6144;
    localparam logic [CFG_BITS-1:0]    LIMIT_RESET  = 15'd3072;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd4095;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BUS_VOLTAGE  = 2'd0,
        CFG_VECTOR_LIMIT = 2'd1,
        CFG_PWM_PERIOD   = 2'd2
    } cfg_index_t;

    typedef logic signed [VOLT_BITS-1:0] sine_rom_t [0:SINE_DEPTH-1];

    // q15 sine by odd taylor series in q30, folded into the first quadrant
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        logic [63:0] ph;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] prod;
        logic signed [63:0] sum;
        logic neg;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            ph  = (64'(k) * 64'd2 * PI_Q30) / SINE_DEPTH;
            neg = 1'b0;
            if (ph >= PI_Q30)
            begin
                ph  = ph - PI_Q30;
                neg = 1'b1;
            end
            if (ph > HALF_PI_Q30)
                ph = (ph <= PI_Q30) ? PI_Q30 - ph : 64'd0;
            x    = ph;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 7; n++)
            begin
                prod = (term * x2) >> 30;
                unique case (n)
                    1:       term = prod / 64'd6;
                    2:       term = prod / 64'd20;
                    3:       term = prod / 64'd42;
                    4:       term = prod / 64'd72;
                    5:       term = prod / 64'd110;
                    6:       term = prod / 64'd156;
                    default: term = prod / 64'd210;
                endcase
                if (n % 2 == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 64'sd0)
                sum = 64'sd0;
            sum = (sum + 64'sd16384) >>> 15;
            if (sum > 64'sd32767)
                sum = 64'sd32767;
            rom[k] = neg ? -16'(sum) : 16'(sum);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

### design/svpwm_park.sv
// inverse park: sine table lookup, four products, round and saturate
// depends on svpwm_pkg
`default_nettype none

module svpwm_park (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [svpwm_pkg::VOLT_BITS-1:0] q_voltage,
    input  logic signed [svpwm_pkg::VOLT_BITS-1:0] d_voltage,
    input  logic [svpwm_pkg::ANGLE_BITS-1:0]       rotor_angle,
    output logic out_valid,
    output logic signed [svpwm_pkg::VOLT_BITS-1:0] alpha,
    output logic signed [svpwm_pkg::VOLT_BITS-1:0] beta
);

    localparam int VB = svpwm_pkg::VOLT_BITS;
    localparam int AB = svpwm_pkg::ANGLE_BITS;
    localparam int AW = svpwm_pkg::SINE_AW;
    localparam int SW = 2 * VB + 1;
    localparam logic [AB-1:0] QUARTER_TURN = AB'(1) << (AB - 2);
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (VB - 2);
    localparam logic signed [SW-1:0] SUM_MAX = SW'((2 ** (VB - 1)) - 1);
    localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;
    localparam svpwm_pkg::sine_rom_t SINE_ROM = svpwm_pkg::build_sine_rom();

    logic [AB-1:0] cos_angle;
    logic [AW-1:0] sin_idx;
    logic [AW-1:0] cos_idx;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic signed [VB-1:0] sin_reg;
    logic signed [VB-1:0] cos_reg;
    logic signed [VB-1:0] q1_reg;
    logic signed [VB-1:0] d1_reg;
    logic signed [2*VB-1:0] cd_reg;
    logic signed [2*VB-1:0] sq_reg;
    logic signed [2*VB-1:0] sd_reg;
    logic signed [2*VB-1:0] cq_reg;
    logic signed [VB-1:0] alpha_reg;
    logic signed [VB-1:0] beta_reg;
    logic signed [VB-1:0] alpha_next;
    logic signed [VB-1:0] beta_next;

    function automatic logic signed [VB-1:0] round_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + ROUND_HALF) >>> (VB - 1);
        if (r > SUM_MAX)
            return SUM_MAX[VB-1:0];
        else if (r < SUM_MIN)
            return SUM_MIN[VB-1:0];
        else
            return r[VB-1:0];
    endfunction

    assign cos_angle = rotor_angle + QUARTER_TURN;
    assign sin_idx   = rotor_angle[AB-1 -: AW];
    assign cos_idx   = cos_angle[AB-1 -: AW];

    assign alpha_next = round_sat(SW'(cd_reg) - SW'(sq_reg));
    assign beta_next  = round_sat(SW'(sd_reg) + SW'(cq_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // table read is registered
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg   <= SINE_ROM[sin_idx];
            cos_reg   <= SINE_ROM[cos_idx];
            q1_reg    <= q_voltage;
            d1_reg    <= d_voltage;
            cd_reg    <= cos_reg * d1_reg;
            sq_reg    <= sin_reg * q1_reg;
            sd_reg    <= sin_reg * d1_reg;
            cq_reg    <= cos_reg * q1_reg;
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
        end
    end

    assign out_valid = v3_reg;
    assign alpha     = alpha_reg;
    assign beta      = beta_reg;

endmodule

`default_nettype wire

### design/svpwm_limit.sv
// magnitude limit: squares, pipelined square root, two pipelined dividers
// depends on svpwm_pkg
`default_nettype none

module svpwm_limit (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [svpwm_pkg::VOLT_BITS-1:0] alpha_in,
    input  logic signed [svpwm_pkg::VOLT_BITS-1:0] beta_in,
    input  logic [svpwm_pkg::CFG_BITS-1:0]         vector_limit,
    output logic out_valid,
    output logic signed [svpwm_pkg::VOLT_BITS-1:0] alpha_out,
    output logic signed [svpwm_pkg::VOLT_BITS-1:0] beta_out
);

    localparam int VB     = svpwm_pkg::VOLT_BITS;
    localparam int CW     = svpwm_pkg::CFG_BITS;
    localparam int SQ_W   = 2 * VB;
    localparam int TW     = SQ_W + 1;
    localparam int ROOT_W = VB;
    localparam int PROD_W = VB + CW;
    localparam int QUO_W  = CW;

    typedef struct packed {
        logic signed [VB-1:0] alpha;
        logic signed [VB-1:0] beta;
        logic                 lim_on;
        logic [PROD_W-1:0]    prod_a;
        logic [PROD_W-1:0]    prod_b;
        logic [SQ_W-1:0]      rem;
        logic [ROOT_W-1:0]    root;
    } root_stage_t;

    typedef struct packed {
        logic signed [VB-1:0] alpha;
        logic signed [VB-1:0] beta;
        logic                 lim_on;
        logic [ROOT_W-1:0]    mag;
        logic [PROD_W-1:0]    rem_a;
        logic [PROD_W-1:0]    rem_b;
        logic [QUO_W-1:0]     quo_a;
        logic [QUO_W-1:0]     quo_b;
    } div_stage_t;

    logic v1_reg;
    logic signed [VB-1:0] a1_reg;
    logic signed [VB-1:0] b1_reg;
    logic [SQ_W-1:0] asq_reg;
    logic [SQ_W-1:0] bsq_reg;
    logic [2*CW-1:0] limsq_reg;

    logic        vroot_reg [0:ROOT_W];
    root_stage_t root_reg  [0:ROOT_W];
    root_stage_t root_next [1:ROOT_W];
    root_stage_t root_first;
    logic [TW-1:0] trial [0:ROOT_W-1];

    logic       vdiv_reg [0:QUO_W];
    div_stage_t div_reg  [0:QUO_W];
    div_stage_t div_next [1:QUO_W];
    div_stage_t div_first;
    logic [PROD_W-1:0] dvs [0:QUO_W-1];

    logic vout_reg;
    logic signed [VB-1:0] alpha_reg;
    logic signed [VB-1:0] beta_reg;

    function automatic logic [VB-1:0] magnitude(input logic signed [VB-1:0] v);
        return v[VB-1] ? (VB'(~v) + VB'(1)) : VB'(v);
    endfunction

    function automatic logic signed [VB-1:0] apply_limit(input logic signed [VB-1:0] x,
                                                         input logic lim_on,
                                                         input logic [QUO_W-1:0] quo);
        if (!lim_on)
            return x;
        else if (x[VB-1])
            return -$signed(VB'(quo));
        else
            return $signed(VB'(quo));
    endfunction

    always_comb
    begin
        root_first.alpha  = a1_reg;
        root_first.beta   = b1_reg;
        root_first.rem    = asq_reg + bsq_reg;
        root_first.lim_on = (vector_limit != '0) && (root_first.rem > SQ_W'(limsq_reg));
        root_first.prod_a = PROD_W'(magnitude(a1_reg)) * PROD_W'(vector_limit);
        root_first.prod_b = PROD_W'(magnitude(b1_reg)) * PROD_W'(vector_limit);
        root_first.root   = '0;
    end

    // one root bit per stage, remainder kept as n - root^2
    always_comb
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            root_next[k+1] = root_reg[k];
            trial[k] = (TW'(root_reg[k].root) << (ROOT_W - k))
                     + (TW'(1) << (2 * (ROOT_W - 1 - k)));
            if (TW'(root_reg[k].rem) >= trial[k])
            begin
                root_next[k+1].rem = root_reg[k].rem - trial[k][SQ_W-1:0];
                root_next[k+1].root[ROOT_W-1-k] = 1'b1;
            end
        end
    end

    // round the root up, then start both divisions
    always_comb
    begin
        div_first.alpha  = root_reg[ROOT_W].alpha;
        div_first.beta   = root_reg[ROOT_W].beta;
        div_first.lim_on = root_reg[ROOT_W].lim_on;
        div_first.mag    = root_reg[ROOT_W].root
                         + ROOT_W'(root_reg[ROOT_W].rem != '0);
        div_first.rem_a  = root_reg[ROOT_W].prod_a;
        div_first.rem_b  = root_reg[ROOT_W].prod_b;
        div_first.quo_a  = '0;
        div_first.quo_b  = '0;
    end

    // restoring division, one quotient bit per stage
    always_comb
    begin
        for (int j = 0; j < QUO_W; j++)
        begin
            div_next[j+1] = div_reg[j];
            dvs[j] = PROD_W'(div_reg[j].mag) << (QUO_W - 1 - j);
            if (div_reg[j].rem_a >= dvs[j])
            begin
                div_next[j+1].rem_a = div_reg[j].rem_a - dvs[j];
                div_next[j+1].quo_a[QUO_W-1-j] = 1'b1;
            end
            if (div_reg[j].rem_b >= dvs[j])
            begin
                div_next[j+1].rem_b = div_reg[j].rem_b - dvs[j];
                div_next[j+1].quo_b[QUO_W-1-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++)
                vroot_reg[k] <= 1'b0;
            for (int j = 0; j <= QUO_W; j++)
                vdiv_reg[j] <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg       <= in_valid;
            vroot_reg[0] <= v1_reg;
            for (int k = 1; k <= ROOT_W; k++)
                vroot_reg[k] <= vroot_reg[k-1];
            vdiv_reg[0] <= vroot_reg[ROOT_W];
            for (int j = 1; j <= QUO_W; j++)
                vdiv_reg[j] <= vdiv_reg[j-1];
            vout_reg <= vdiv_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg      <= alpha_in;
            b1_reg      <= beta_in;
            asq_reg     <= alpha_in * alpha_in;
            bsq_reg     <= beta_in * beta_in;
            limsq_reg   <= vector_limit * vector_limit;
            root_reg[0] <= root_first;
            for (int k = 1; k <= ROOT_W; k++)
                root_reg[k] <= root_next[k];
            div_reg[0] <= div_first;
            for (int j = 1; j <= QUO_W; j++)
                div_reg[j] <= div_next[j];
            alpha_reg <= apply_limit(div_reg[QUO_W].alpha, div_reg[QUO_W].lim_on,
                                     div_reg[QUO_W].quo_a);
            beta_reg  <= apply_limit(div_reg[QUO_W].beta, div_reg[QUO_W].lim_on,
                                     div_reg[QUO_W].quo_b);
        end
    end

    assign out_valid = vout_reg;
    assign alpha_out = alpha_reg;
    assign beta_out  = beta_reg;

endmodule

`default_nettype wire

### design/svpwm_phase.sv
// clarke, min/max injection, duty clamp and three pipelined compare dividers
// depends on svpwm_pkg
`default_nettype none

module svpwm_phase (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [svpwm_pkg::VOLT_BITS-1:0] alpha_in,
    input  logic signed [svpwm_pkg::VOLT_BITS-1:0] beta_in,
    input  logic [svpwm_pkg::CFG_BITS-1:0]         bus_voltage,
    input  logic [svpwm_pkg::PERIOD_BITS-1:0]      pwm_period,
    output logic out_valid,
    output logic signed [svpwm_pkg::VOLT_BITS-1:0] alpha_out,
    output logic signed [svpwm_pkg::VOLT_BITS-1:0] beta_out,
    output logic [2:0][svpwm_pkg::PERIOD_BITS-1:0] compare,
    output logic [2:0][svpwm_pkg::CFG_BITS-1:0]    volts
);

    localparam int VB   = svpwm_pkg::VOLT_BITS;
    localparam int CW   = svpwm_pkg::CFG_BITS;
    localparam int PB   = svpwm_pkg::PERIOD_BITS;
    localparam int PW   = 2 * VB + 2;
    localparam int XW   = PW + 2;
    localparam int NSW  = XW + 1;
    localparam int NUMW = CW + 16;
    localparam int MW   = NUMW + PB;

    typedef struct packed {
        logic signed [VB-1:0]      alpha;
        logic signed [VB-1:0]      beta;
        logic [2:0][NUMW-1:0]      rem;
        logic [2:0][PB-1:0]        quo;
        logic [2:0][CW-1:0]        volts;
    } duty_stage_t;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v5_reg;
    logic signed [VB-1:0] a1_reg, b1_reg, a2_reg, b2_reg, a3_reg, b3_reg;
    logic signed [VB-1:0] a4_reg, b4_reg, a5_reg, b5_reg;
    logic signed [2*VB-1:0] bk_reg;
    logic signed [PW-1:0] p2_reg [0:2];
    logic signed [PW-1:0] p3_reg [0:2];
    logic signed [PW:0]   mid_reg;
    logic signed [XW-1:0] ph4_reg [0:2];
    logic [NUMW-1:0]      num5_reg [0:2];

    logic signed [PW-1:0] p_next [0:2];
    logic signed [PW-1:0] p_max;
    logic signed [PW-1:0] p_min;
    logic signed [XW-1:0] ph_next [0:2];
    logic signed [NSW-1:0] num_raw [0:2];
    logic [NUMW-1:0]      num_next [0:2];
    logic [CW+14:0]       half_bus;
    logic [NUMW-1:0]      den;
    logic [MW-1:0]        prod [0:2];

    logic        vdiv_reg [0:PB];
    duty_stage_t div_reg  [0:PB];
    duty_stage_t div_next [1:PB];
    duty_stage_t div_first;
    logic [NUMW-1:0] dvs [0:PB-1];

    assign half_bus = {bus_voltage, 15'b0};
    assign den      = {bus_voltage, 16'b0};

    always_comb
    begin
        p_next[0] = PW'(a1_reg) <<< (VB - 1);
        p_next[1] = -(PW'(a1_reg) <<< (VB - 2)) + PW'(bk_reg);
        p_next[2] = -(PW'(a1_reg) <<< (VB - 2)) - PW'(bk_reg);
    end

    always_comb
    begin
        p_max = p2_reg[0];
        p_min = p2_reg[0];
        for (int x = 1; x < 3; x++)
        begin
            if (p2_reg[x] > p_max)
                p_max = p2_reg[x];
            if (p2_reg[x] < p_min)
                p_min = p2_reg[x];
        end
    end

    // clamp of half bus minus phase to 0..den
    always_comb
    begin
        for (int x = 0; x < 3; x++)
        begin
            ph_next[x] = (XW'(p3_reg[x]) <<< 1) - XW'(mid_reg);
            num_raw[x] = $signed(NSW'(half_bus)) - NSW'(ph4_reg[x]);
            if (num_raw[x] < 0)
                num_next[x] = '0;
            else if (num_raw[x] > $signed(NSW'(den)))
                num_next[x] = den;
            else
                num_next[x] = num_raw[x][NUMW-1:0];
        end
    end

    always_comb
    begin
        div_first.alpha = a5_reg;
        div_first.beta  = b5_reg;
        for (int x = 0; x < 3; x++)
        begin
            prod[x]            = MW'(num5_reg[x]) * MW'(pwm_period);
            div_first.rem[x]   = prod[x][MW-1:16];
            div_first.quo[x]   = '0;
            div_first.volts[x] = CW'((den - num5_reg[x]) >> 16);
        end
    end

    // dividing by the bus voltage, one compare bit per stage
    always_comb
    begin
        for (int j = 0; j < PB; j++)
        begin
            div_next[j+1] = div_reg[j];
            dvs[j] = NUMW'(bus_voltage) << (PB - 1 - j);
            for (int x = 0; x < 3; x++)
            begin
                if (div_reg[j].rem[x] >= dvs[j])
                begin
                    div_next[j+1].rem[x] = div_reg[j].rem[x] - dvs[j];
                    div_next[j+1].quo[x][PB-1-j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int j = 0; j <= PB; j++)
                vdiv_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vdiv_reg[0] <= v5_reg;
            for (int j = 1; j <= PB; j++)
                vdiv_reg[j] <= vdiv_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= alpha_in;
            b1_reg  <= beta_in;
            bk_reg  <= beta_in * svpwm_pkg::SQRT3_HALF_Q15;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            a3_reg  <= a2_reg;
            b3_reg  <= b2_reg;
            a4_reg  <= a3_reg;
            b4_reg  <= b3_reg;
            a5_reg  <= a4_reg;
            b5_reg  <= b4_reg;
            mid_reg <= (PW+1)'(p_max) + (PW+1)'(p_min);
            for (int x = 0; x < 3; x++)
            begin
                p2_reg[x]   <= p_next[x];
                p3_reg[x]   <= p2_reg[x];
                ph4_reg[x]  <= ph_next[x];
                num5_reg[x] <= num_next[x];
            end
            div_reg[0] <= div_first;
            for (int j = 1; j <= PB; j++)
                div_reg[j] <= div_next[j];
        end
    end

    assign out_valid = vdiv_reg[PB];
    assign alpha_out = div_reg[PB].alpha;
    assign beta_out  = div_reg[PB].beta;
    assign compare   = div_reg[PB].quo;
    assign volts     = div_reg[PB].volts;

endmodule

`default_nettype wire

### design/svpwm_min_max_injection_modulator.sv
// top level of the space-vector modulator: ports, configuration registers,
// output register; depends on svpwm_pkg, svpwm_park, svpwm_limit, svpwm_phase
//
// usage: one q/d/angle command per s_ transfer, one result per m_ transfer.
// s_tdata: q_voltage [15:0], d_voltage [31:16], rotor_angle [47:32].
// m_tdata: compares a/b/c, alpha, beta, phase a/b/c volts; m_tuser: bus_fault.
// configuration: cfg_index selects bus voltage, vector limit or pwm period;
// cfg_ready is always high and a write takes effect on the next cycle.
// write configuration only while no result is outstanding.
// depth: 61 register stages; the square root (16 stages) and the two dividers
// (15 and 16 stages) make up most of it.
// throughput: one command per cycle unless the output stalls;
// every stage advances together.
// when the receiver stalls with a result waiting, s_tready drops and the whole
// pipeline holds; nothing is lost or repeated.
// reset clears all valid bits and loads bus 6144, limit 3072, period 4095.
// a zero bus voltage gives bus_fault with all other fields zero.
`default_nettype none
`include "svpwm_min_max_injection_modulator_defines.svh"

module svpwm_min_max_injection_modulator (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // q_voltage, d_voltage, rotor_angle
    input  logic [svpwm_pkg::IN_TDATA_BITS-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // compare_a, compare_b, compare_c, alpha_out, beta_out,
    // phase_a_volts, phase_b_volts, phase_c_volts, zero pad
    output logic [svpwm_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    // bus_fault
    output logic m_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [svpwm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [svpwm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int VB = svpwm_pkg::VOLT_BITS;
    localparam int CW = svpwm_pkg::CFG_BITS;
    localparam int PB = svpwm_pkg::PERIOD_BITS;
    localparam int OW = svpwm_pkg::OUT_TDATA_BITS;
    localparam int PAD = OW - 5 * VB - 3 * CW;

    logic en;
    logic [CW-1:0] bus_voltage_reg;
    logic [CW-1:0] vector_limit_reg;
    logic [PB-1:0] pwm_period_reg;

    logic park_valid;
    logic signed [VB-1:0] park_alpha;
    logic signed [VB-1:0] park_beta;
    logic lim_valid;
    logic signed [VB-1:0] lim_alpha;
    logic signed [VB-1:0] lim_beta;
    logic phase_valid;
    logic signed [VB-1:0] phase_alpha;
    logic signed [VB-1:0] phase_beta;
    logic [2:0][PB-1:0] compare;
    logic [2:0][CW-1:0] volts;

    logic m_valid_reg;
    logic fault_reg;
    logic [OW-1:0] tdata_reg;
    logic [OW-1:0] tdata_next;

    // global advance: the output register is free or being emptied
    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_voltage_reg  <= svpwm_pkg::BUS_RESET;
            vector_limit_reg <= svpwm_pkg::LIMIT_RESET;
            pwm_period_reg   <= svpwm_pkg::PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                svpwm_pkg::CFG_BUS_VOLTAGE:  bus_voltage_reg  <= cfg_data[CW-1:0];
                svpwm_pkg::CFG_VECTOR_LIMIT: vector_limit_reg <= cfg_data[CW-1:0];
                svpwm_pkg::CFG_PWM_PERIOD:   pwm_period_reg   <= cfg_data[PB-1:0];
                default: ;
            endcase
        end
    end

    svpwm_park u_park (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_tvalid),
        .q_voltage   (s_tdata[VB-1:0]),
        .d_voltage   (s_tdata[2*VB-1:VB]),
        .rotor_angle (s_tdata[2*VB+svpwm_pkg::ANGLE_BITS-1:2*VB]),
        .out_valid   (park_valid),
        .alpha       (park_alpha),
        .beta        (park_beta)
    );

    svpwm_limit u_limit (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (park_valid),
        .alpha_in     (park_alpha),
        .beta_in      (park_beta),
        .vector_limit (vector_limit_reg),
        .out_valid    (lim_valid),
        .alpha_out    (lim_alpha),
        .beta_out     (lim_beta)
    );

    svpwm_phase u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (lim_valid),
        .alpha_in    (lim_alpha),
        .beta_in     (lim_beta),
        .bus_voltage (bus_voltage_reg),
        .pwm_period  (pwm_period_reg),
        .out_valid   (phase_valid),
        .alpha_out   (phase_alpha),
        .beta_out    (phase_beta),
        .compare     (compare),
        .volts       (volts)
    );

    assign tdata_next = {PAD'(0), volts[2], volts[1], volts[0],
                         phase_beta, phase_alpha, compare[2], compare[1], compare[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= phase_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fault_reg <= (bus_voltage_reg == '0);
            tdata_reg <= (bus_voltage_reg == '0) ? '0 : tdata_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = fault_reg;

    `SVPWM_ASSERT_IMP(a_fault_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0)
    `SVPWM_ASSERT_IMP(a_stall_closes_input, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    `SVPWM_ASSERT_NEXT(a_cfg_bus_write, clk, rst_n, cfg_valid && cfg_ready && cfg_index == svpwm_pkg::CFG_BUS_VOLTAGE, bus_voltage_reg == $past(cfg_data[CW-1:0]))

endmodule

`default_nettype wire

### sim/svpwm_min_max_injection_modulator_tb.sv
// self-checking bench for the space-vector modulator with min/max injection
// drives q/d/angle commands, predicts every result field and compares in order
// depends on svpwm_pkg and svpwm_min_max_injection_modulator
`timescale 1ns / 100ps
`default_nettype none

module svpwm_min_max_injection_modulator_tb;

    localparam int LATENCY     = 61;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] d;
        logic [15:0] q;
    } command_t;

    typedef struct packed {
        logic [2:0]  pad;
        logic [14:0] volts_c;
        logic [14:0] volts_b;
        logic [14:0] volts_a;
        logic [15:0] beta;
        logic [15:0] alpha;
        logic [15:0] cmp_c;
        logic [15:0] cmp_b;
        logic [15:0] cmp_a;
    } duty_result_t;

    typedef struct packed {
        duty_result_t data;
        logic         fault;
    } modulator_out_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [svpwm_pkg::IN_TDATA_BITS-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [svpwm_pkg::OUT_TDATA_BITS-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [svpwm_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [svpwm_pkg::CFG_DATA_BITS-1:0] cfg_data;

    svpwm_min_max_injection_modulator u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    logic signed [15:0] sine_q15 [0:svpwm_pkg::SINE_DEPTH-1];
    longint bus_q8;
    longint limit_q8;
    longint period_counts;

    command_t       command_queue [$];
    modulator_out_t expected_queue [$];
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  hold_count;
    int  errors;
    int  quiet_cycles;

    // q15 sine by odd taylor series in q30
    task automatic fill_sine();
        longint unsigned ph, x2, term;
        longint sum;
        bit neg;
        for (int k = 0; k < svpwm_pkg::SINE_DEPTH; k++)
        begin
            ph = (longint'(k) * 2 * 64'd3373259426) / svpwm_pkg::SINE_DEPTH;
            neg = 1'b0;
            if (ph >= 64'd3373259426)
            begin
                ph -= 64'd3373259426;
                neg = 1'b1;
            end
            if (ph > 64'd1686629713)
                ph = 64'd3373259426 - ph;
            x2 = (ph * ph) >> 30;
            term = ph;
            sum = longint'(ph);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum -= longint'(term);
                else
                    sum += longint'(term);
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + 16384) >>> 15;
            if (sum > 32767)
                sum = 32767;
            sine_q15[k] = neg ? -16'(sum) : 16'(sum);
        end
    endtask

    function automatic longint round_q15(longint v);
        longint w;
        w = v + 16384;
        if (w >= 0)
            return w >>> 15;
        return -((-w + 32767) >>> 15);
    endfunction

    function automatic longint clip_volt(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic longint root_up(longint n);
        longint r;
        r = longint'($sqrt(real'(n)));
        while (r * r > n)
            r--;
        while (r * r < n)
            r++;
        return r;
    endfunction

    function automatic void phase_duty(longint p, output logic [15:0] cmp,
                                       output logic [14:0] volts);
        longint den, num;
        den = 65536 * bus_q8;
        num = 32768 * bus_q8 - p;
        if (num < 0)
            num = 0;
        if (num > den)
            num = den;
        cmp = 16'((num * period_counts) / den);
        volts = 15'((den - num) >>> 16);
    endfunction

    function automatic modulator_out_t predict_duty(command_t cmd);
        modulator_out_t r;
        longint q, d, s, c, al, be, sq, mag, pa, pb, pc, mx, mn, mid;
        int si, ci;
        r = '0;
        if (bus_q8 == 0)
        begin
            r.fault = 1'b1;
            return r;
        end
        q = longint'($signed(cmd.q));
        d = longint'($signed(cmd.d));
        si = (int'(cmd.angle) * svpwm_pkg::SINE_DEPTH) >> svpwm_pkg::ANGLE_BITS;
        ci = (int'(16'(cmd.angle + 16'h4000)) * svpwm_pkg::SINE_DEPTH)
             >> svpwm_pkg::ANGLE_BITS;
        s = sine_q15[si];
        c = sine_q15[ci];
        al = clip_volt(round_q15(c * d - s * q));
        be = clip_volt(round_q15(s * d + c * q));
        sq = al * al + be * be;
        if (limit_q8 != 0 && sq > limit_q8 * limit_q8)
        begin
            mag = root_up(sq);
            al = al < 0 ? -((-al * limit_q8) / mag) : (al * limit_q8) / mag;
            be = be < 0 ? -((-be * limit_q8) / mag) : (be * limit_q8) / mag;
        end
        pa = al * 32768;
        pb = -al * 16384 + be * 28378;
        pc = -al * 16384 - be * 28378;
        mx = pa;
        mn = pa;
        if (pb > mx) mx = pb;
        if (pc > mx) mx = pc;
        if (pb < mn) mn = pb;
        if (pc < mn) mn = pc;
        mid = mx + mn;
        phase_duty(2 * pa - mid, r.data.cmp_a, r.data.volts_a);
        phase_duty(2 * pb - mid, r.data.cmp_b, r.data.volts_b);
        phase_duty(2 * pc - mid, r.data.cmp_c, r.data.volts_c);
        r.data.alpha = 16'(al);
        r.data.beta = 16'(be);
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready)
            begin
                if (command_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    command_t cmd;
                    cmd = command_queue.pop_front();
                    expected_queue.push_back(predict_duty(cmd));
                    s_tdata <= cmd;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (recv_hold)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                modulator_out_t got, want;
                got = {duty_result_t'(m_tdata), m_tuser};
                if (expected_queue.size() == 0)
                begin
                    $display("%0t unexpected result %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_queue.pop_front();
                    if (got.data.cmp_a !== want.data.cmp_a)
                        $display("%0t compare_a exp %0d got %0d", $time, want.data.cmp_a, got.data.cmp_a);
                    if (got.data.cmp_b !== want.data.cmp_b)
                        $display("%0t compare_b exp %0d got %0d", $time, want.data.cmp_b, got.data.cmp_b);
                    if (got.data.cmp_c !== want.data.cmp_c)
                        $display("%0t compare_c exp %0d got %0d", $time, want.data.cmp_c, got.data.cmp_c);
                    if (got.data.alpha !== want.data.alpha)
                        $display("%0t alpha exp %0d got %0d", $time, $signed(want.data.alpha), $signed(got.data.alpha));
                    if (got.data.beta !== want.data.beta)
                        $display("%0t beta exp %0d got %0d", $time, $signed(want.data.beta), $signed(got.data.beta));
                    if (got.data.volts_a !== want.data.volts_a)
                        $display("%0t phase_a_volts exp %0d got %0d", $time, want.data.volts_a, got.data.volts_a);
                    if (got.data.volts_b !== want.data.volts_b)
                        $display("%0t phase_b_volts exp %0d got %0d", $time, want.data.volts_b, got.data.volts_b);
                    if (got.data.volts_c !== want.data.volts_c)
                        $display("%0t phase_c_volts exp %0d got %0d", $time, want.data.volts_c, got.data.volts_c);
                    if (got.data.pad !== want.data.pad)
                        $display("%0t pad exp %h got %h", $time, want.data.pad, got.data.pad);
                    if (got.fault !== want.fault)
                        $display("%0t bus_fault exp %0b got %0b", $time, want.fault, got.fault);
                    if (got !== want)
                        errors++;
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver hold-off counted here
    always @(posedge clk)
    begin
        if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
            recv_hold <= (hold_count > 1);
        end
    end

    task automatic wait_drained();
        while (command_queue.size() > 0 || s_tvalid || expected_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(svpwm_pkg::cfg_index_t idx, logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            svpwm_pkg::CFG_BUS_VOLTAGE:  bus_q8 = value[14:0];
            svpwm_pkg::CFG_VECTOR_LIMIT: limit_q8 = value[14:0];
            default:                     period_counts = value;
        endcase
    endtask

    task automatic set_regs(logic [15:0] bus, logic [15:0] lim, logic [15:0] per);
        write_reg(svpwm_pkg::CFG_BUS_VOLTAGE, bus);
        write_reg(svpwm_pkg::CFG_VECTOR_LIMIT, lim);
        write_reg(svpwm_pkg::CFG_PWM_PERIOD, per);
    endtask

    function automatic logic [15:0] pick_volt();
        case ($urandom_range(5))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(32767, 32700));
            2:       return 16'(-$urandom_range(32768, 32700));
            default: return 16'($signed(12'($urandom)));
        endcase
    endfunction

    task automatic queue_random(int count);
        command_t cmd;
        repeat (count)
        begin
            cmd.q = pick_volt();
            cmd.d = pick_volt();
            cmd.angle = 16'($urandom);
            command_queue.push_back(cmd);
        end
    endtask

    initial
    begin
        command_t cmd;
        errors = 0;
        quiet_cycles = 0;
        recv_hold = 1'b0;
        hold_count = 0;
        send_idle_pct = 24;
        recv_idle_pct = 47;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = svpwm_pkg::CFG_BUS_VOLTAGE;
        cfg_data = '0;
        bus_q8 = svpwm_pkg::BUS_RESET;
        limit_q8 = svpwm_pkg::LIMIT_RESET;
        period_counts = svpwm_pkg::PERIOD_RESET;
        fill_sine();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of q, d and angle, quadrant boundaries
        foreach (cmd.q[i])
        begin
            cmd = '0;
            cmd.q = 16'(1 << i);
            cmd.d = ~16'(1 << i);
            cmd.angle = 16'(1 << i);
            command_queue.push_back(cmd);
        end
        command_queue.push_back({16'h0000, 16'h7fff, 16'h7fff});
        command_queue.push_back({16'h4000, 16'h8000, 16'h8000});
        command_queue.push_back({16'h8000, 16'h7fff, 16'h8000});
        command_queue.push_back({16'hffff, 16'h0000, 16'h0000});
        command_queue.push_back({16'hc000, 16'h0100, 16'hff00});
        command_queue.push_back({16'h2000, 16'h0000, 16'h0080});
        wait_drained();

        // no limit, big bus
        set_regs(16'h7fff, 16'h0000, 16'hffff);
        queue_random(150);
        wait_drained();

        // tiny bus clamps duty, smallest period
        set_regs(16'h0001, 16'h7fff, 16'h0001);
        queue_random(100);
        wait_drained();

        // bus fault
        set_regs(16'h0000, 16'h0001, 16'h0000);
        queue_random(40);
        wait_drained();

        set_regs(16'd6144, 16'd3072, 16'd4095);
        send_idle_pct = 47;
        recv_idle_pct = 24;
        queue_random(250);
        hold_count = HOLD_CYCLES;
        recv_hold = 1'b1;
        wait_drained();

        set_regs(16'($urandom_range(32767, 1)), 16'($urandom_range(32767)),
                 16'($urandom_range(65535, 1)));
        queue_random(250);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(16'd2400, 16'd1000, 16'd10000);
        queue_random(300);
        wait_drained();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### svpwm_min_max_injection_modulator.f
+incdir+design
design/svpwm_pkg.sv
design/svpwm_park.sv
design/svpwm_limit.sv
design/svpwm_phase.sv
design/svpwm_min_max_injection_modulator.sv
sim/svpwm_min_max_injection_modulator_tb.sv
